// ===== rtl/ia_pkg.sv =====
// Package for the integer ALU: operation codes, pipeline constants and the
// tag struct that travels with an item. No dependencies.
package ia_pkg;

    localparam int XLEN       = 64;
    localparam int HLEN       = 32;
    localparam int DIV_STAGES = 64;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_SDIVN = 4'd3;
    localparam logic [3:0] OP_SREMN = 4'd4;
    localparam logic [3:0] OP_AND   = 4'd5;
    localparam logic [3:0] OP_OR    = 4'd6;
    localparam logic [3:0] OP_XOR   = 4'd7;
    localparam logic [3:0] OP_SHL   = 4'd8;
    localparam logic [3:0] OP_SRA   = 4'd9;
    localparam logic [3:0] OP_SDIVW = 4'd10;
    localparam logic [3:0] OP_SREMW = 4'd11;
    localparam logic [3:0] OP_UDIV  = 4'd12;
    localparam logic [3:0] OP_UREM  = 4'd13;
    localparam logic [3:0] OP_NOT   = 4'd14;
    localparam logic [3:0] OP_SRL   = 4'd15;

    typedef struct packed {
        logic [XLEN-1:0] res;
        logic            is_mul;
        logic            is_div;
        logic            want_rem;
        logic            neg_q;
        logic            neg_r;
        logic            zero_res;
        logic            dz;
        logic            bad;
        logic            wide;
    } t_tag;

endpackage

// ===== rtl/ia_mul.sv =====
// Two-stage 64-bit multiplier (low half of the product) built from three
// 32x32 partial products. Carries the item tag and divider operands. Uses ia_pkg.
module ia_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ia_pkg::t_tag      i_tag,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    input  logic [63:0]       i_ma,
    input  logic [63:0]       i_mb,
    output logic              o_valid,
    output ia_pkg::t_tag      o_tag,
    output logic [63:0]       o_ma,
    output logic [63:0]       o_mb
);
    import ia_pkg::*;

    logic            r_v1;
    t_tag            r_tag1;
    logic [63:0]     r_p0;
    logic [63:0]     r_p1;
    logic [63:0]     r_p2;
    logic [63:0]     r_ma1;
    logic [63:0]     r_mb1;
    logic            r_v2;
    t_tag            r_tag2;
    logic [63:0]     r_ma2;
    logic [63:0]     r_mb2;
    logic [HLEN-1:0] n_cross;
    logic [63:0]     n_prod;
    t_tag            n_tag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag1 <= i_tag;
            r_p0   <= i_a[31:0] * i_b[31:0];
            r_p1   <= i_a[31:0] * i_b[63:32];
            r_p2   <= i_a[63:32] * i_b[31:0];
            r_ma1  <= i_ma;
            r_mb1  <= i_mb;
            r_tag2 <= n_tag2;
            r_ma2  <= r_ma1;
            r_mb2  <= r_mb1;
        end
    end

    always_comb begin
        n_cross = r_p1[HLEN-1:0] + r_p2[HLEN-1:0];
        n_prod  = r_p0 + {n_cross, {HLEN{1'b0}}};
        n_tag2  = r_tag1;
        if (r_tag1.is_mul) begin
            n_tag2.res = n_prod;
        end
    end

    assign o_valid = r_v2;
    assign o_tag   = r_tag2;
    assign o_ma    = r_ma2;
    assign o_mb    = r_mb2;
endmodule

// ===== rtl/ia_div.sv =====
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// The item tag travels alongside. Uses ia_pkg.
module ia_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ia_pkg::t_tag      i_tag,
    input  logic [63:0]       i_dividend,
    input  logic [63:0]       i_divisor,
    output logic              o_valid,
    output ia_pkg::t_tag      o_tag,
    output logic [63:0]       o_quo,
    output logic [63:0]       o_rem
);
    import ia_pkg::*;

    typedef struct packed {
        logic            valid;
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] dvs;
        t_tag            tag;
    } t_dstage;

    t_dstage n_head;
    t_dstage r_st [1:DIV_STAGES];

    always_comb begin
        n_head.valid = i_valid;
        n_head.rem   = '0;
        n_head.quo   = i_dividend;
        n_head.dvs   = i_divisor;
        n_head.tag   = i_tag;
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        t_dstage       st_in;
        logic [XLEN:0] n_shift;
        logic [XLEN:0] n_diff;
        t_dstage       n_st;

        if (g == 0) begin : g_first
            assign st_in = n_head;
        end else begin : g_next
            assign st_in = r_st[g];
        end

        always_comb begin
            n_shift = {st_in.rem, st_in.quo[XLEN-1]};
            n_diff  = n_shift - {1'b0, st_in.dvs};
            n_st    = st_in;
            if (!n_diff[XLEN]) begin
                n_st.rem = n_diff[XLEN-1:0];
            end else begin
                n_st.rem = n_shift[XLEN-1:0];
            end
            n_st.quo = {st_in.quo[XLEN-2:0], ~n_diff[XLEN]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[g+1].valid <= 1'b0;
            end else if (i_en) begin
                r_st[g+1].valid <= n_st.valid;
            end
            if (i_en) begin
                r_st[g+1].rem <= n_st.rem;
                r_st[g+1].quo <= n_st.quo;
                r_st[g+1].dvs <= n_st.dvs;
                r_st[g+1].tag <= n_st.tag;
            end
        end
    end

    assign o_valid = r_st[DIV_STAGES].valid;
    assign o_tag   = r_st[DIV_STAGES].tag;
    assign o_quo   = r_st[DIV_STAGES].quo;
    assign o_rem   = r_st[DIV_STAGES].rem;
endmodule

// ===== rtl/integer_alu_32_64.sv =====
// Top level of the 32/64-bit integer ALU: input register, decode stage,
// multiplier, divider pipeline and result stage. Uses ia_pkg, ia_mul, ia_div.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------
//  input   | i_valid | o_stall | i_op, i_wide, i_operand_a, i_operand_b
//  output  | o_valid | i_stall | o_result, o_div_by_zero, o_bad_op
//
// One item enters per cycle while o_stall is low; every item passes through the
// input register, decode, two multiplier stages, the 64 one-bit stages of the
// divider and the result stage.
// Reset clears only the valid bits. A stall at the output holds the whole
// pipeline, and o_stall follows it, so nothing is lost or repeated.
module integer_alu_32_64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_op,
    input  logic        i_wide,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result,
    output logic        o_div_by_zero,
    output logic        o_bad_op
);
    import ia_pkg::*;

    logic        en;
    logic        r_v0;
    logic [3:0]  r_op;
    logic        r_wide;
    logic [63:0] r_a;
    logic [63:0] r_b;

    logic        r_v1;
    t_tag        r_tag1;
    logic [63:0] r_ae;
    logic [63:0] r_be;
    logic [63:0] r_ma;
    logic [63:0] r_mb;

    t_tag        n_tag;
    logic [63:0] n_ae;
    logic [63:0] n_be;
    logic [5:0]  n_sh;
    logic        n_na;
    logic        n_nb;
    logic        n_sdiv;

    logic        m_valid;
    t_tag        m_tag;
    logic [63:0] m_ma;
    logic [63:0] m_mb;
    logic        d_valid;
    t_tag        d_tag;
    logic [63:0] d_quo;
    logic [63:0] d_rem;

    logic [63:0] n_res;
    logic        r_out_valid;
    logic [63:0] r_result;
    logic        r_dz;
    logic        r_bad;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v0        <= i_valid;
            r_v1        <= r_v0;
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op     <= i_op;
            r_wide   <= i_wide;
            r_a      <= i_operand_a;
            r_b      <= i_operand_b;
            r_tag1   <= n_tag;
            r_ae     <= n_ae;
            r_be     <= n_be;
            r_ma     <= n_na ? 64'd0 - n_ae : n_ae;
            r_mb     <= n_nb ? 64'd0 - n_be : n_be;
            r_result <= n_res;
            r_dz     <= d_tag.dz;
            r_bad    <= d_tag.bad;
        end
    end

    always_comb begin
        n_ae   = r_wide ? r_a : {{32{r_a[31]}}, r_a[31:0]};
        n_be   = r_wide ? r_b : {{32{r_b[31]}}, r_b[31:0]};
        n_sh   = r_wide ? r_b[5:0] : {1'b0, r_b[4:0]};
        n_tag  = '0;
        n_tag.wide = r_wide;
        n_sdiv = 1'b0;
        case (r_op)
            OP_ADD: n_tag.res = n_ae + n_be;
            OP_SUB: n_tag.res = n_ae - n_be;
            OP_MUL: n_tag.is_mul = 1'b1;
            OP_AND: n_tag.res = n_ae & n_be;
            OP_OR:  n_tag.res = n_ae | n_be;
            OP_XOR: n_tag.res = n_ae ^ n_be;
            OP_SHL: n_tag.res = n_ae << n_sh;
            OP_SRA: n_tag.res = $unsigned($signed(n_ae) >>> n_sh);
            OP_SDIVN, OP_SREMN: begin
                n_tag.bad      = r_wide;
                n_tag.is_div   = !r_wide;
                n_tag.want_rem = (r_op == OP_SREMN);
                n_sdiv         = 1'b1;
            end
            OP_SDIVW, OP_SREMW, OP_UDIV, OP_UREM: begin
                n_tag.bad      = !r_wide;
                n_tag.is_div   = r_wide;
                n_tag.want_rem = (r_op == OP_SREMW) || (r_op == OP_UREM);
                n_sdiv         = (r_op == OP_SDIVW) || (r_op == OP_SREMW);
            end
            OP_NOT: begin
                n_tag.bad = !r_wide;
                n_tag.res = ~n_ae;
            end
            OP_SRL: begin
                n_tag.bad = !r_wide;
                n_tag.res = n_ae >> n_sh;
            end
            default: n_tag.bad = 1'b1;
        endcase
        n_na        = n_sdiv && n_ae[63];
        n_nb        = n_sdiv && n_be[63];
        n_tag.neg_r = n_na;
        n_tag.neg_q = n_na ^ n_nb;
        n_tag.dz    = n_tag.is_div && r_wide && (n_be == 64'd0);
        n_tag.zero_res = n_tag.bad || (n_tag.is_div && (n_be == 64'd0));
        if (!r_v0) begin
            n_tag.bad = 1'b0;
            n_tag.dz  = 1'b0;
        end
    end

    ia_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_tag   (r_tag1),
        .i_a     (r_ae),
        .i_b     (r_be),
        .i_ma    (r_ma),
        .i_mb    (r_mb),
        .o_valid (m_valid),
        .o_tag   (m_tag),
        .o_ma    (m_ma),
        .o_mb    (m_mb)
    );

    ia_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (m_valid),
        .i_tag      (m_tag),
        .i_dividend (m_ma),
        .i_divisor  (m_mb),
        .o_valid    (d_valid),
        .o_tag      (d_tag),
        .o_quo      (d_quo),
        .o_rem      (d_rem)
    );

    always_comb begin
        n_res = d_tag.res;
        if (d_tag.is_div) begin
            if (d_tag.want_rem) begin
                n_res = d_tag.neg_r ? 64'd0 - d_rem : d_rem;
            end else begin
                n_res = d_tag.neg_q ? 64'd0 - d_quo : d_quo;
            end
        end
        if (d_tag.zero_res) begin
            n_res = 64'd0;
        end
        if (!d_tag.wide) begin
            n_res = {{32{n_res[31]}}, n_res[31:0]};
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result      = r_result;
    assign o_div_by_zero = r_dz;
    assign o_bad_op      = r_bad;

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_op) |-> (o_result == 64'd0 && !o_div_by_zero))
        else $error("An item with a bad opcode has a nonzero result.");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_by_zero) |-> (o_result == 64'd0))
        else $error("A divide by zero gave a nonzero result.");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("A stalled result item was lost or changed.");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("The input side stalled without an output stall.");
`endif
endmodule

// ===== tb/sv/tb_integer_alu_32_64_checker.sv =====
`timescale 1ns / 100ps
// Checker for the 32/64-bit integer ALU: watches both channels, predicts
// each result from the accepted item and compares. Uses ia_pkg.
module tb_integer_alu_32_64_checker
    import ia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_op,
    input  logic        i_wide,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic        i_out_valid,
    input  logic        i_stall,
    input  logic [63:0] i_result,
    input  logic        i_div_by_zero,
    input  logic        i_bad_op,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] result;
        logic        dz;
        logic        bad;
    } t_alu_out;

    t_alu_out alu_expected_q[$];

    function automatic logic [63:0] sx32(logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] sdiv64(logic [63:0] a, logic [63:0] b, bit rem);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (rem) return a[63] ? -r : r;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic t_alu_out alu_predict(logic [3:0] op, logic wide,
                                             logic [63:0] a0, logic [63:0] b0);
        t_alu_out o;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        o = '0;
        r = '0;
        if (!wide) begin
            a = sx32(a0);
            b = sx32(b0);
            case (op)
                OP_ADD:   r = a + b;
                OP_SUB:   r = a - b;
                OP_MUL:   r = {32'd0, a[31:0]} * {32'd0, b[31:0]};
                OP_SDIVN: r = (b == 0) ? '0 : sdiv64(a, b, 1'b0);
                OP_SREMN: r = (b == 0) ? '0 : sdiv64(a, b, 1'b1);
                OP_AND:   r = a & b;
                OP_OR:    r = a | b;
                OP_XOR:   r = a ^ b;
                OP_SHL:   r = {32'd0, a[31:0]} << b[4:0];
                OP_SRA:   r = $signed(a) >>> b[4:0];
                default:  o.bad = 1'b1;
            endcase
            o.result = o.bad ? '0 : sx32(r);
        end else begin
            a = a0;
            b = b0;
            case (op)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                OP_AND: r = a & b;
                OP_OR:  r = a | b;
                OP_XOR: r = a ^ b;
                OP_SHL: r = a << b[5:0];
                OP_SRA: r = $signed(a) >>> b[5:0];
                OP_SDIVW, OP_SREMW, OP_UDIV, OP_UREM: begin
                    if (b == 0) o.dz = 1'b1;
                    else if (op == OP_SDIVW) r = sdiv64(a, b, 1'b0);
                    else if (op == OP_SREMW) r = sdiv64(a, b, 1'b1);
                    else if (op == OP_UDIV) r = a / b;
                    else r = a % b;
                end
                OP_NOT: r = ~a;
                OP_SRL: r = a >> b[5:0];
                default: o.bad = 1'b1;
            endcase
            o.result = r;
        end
        return o;
    endfunction

    initial o_errors = 0;
    assign o_pending = alu_expected_q.size();

    always @(posedge i_clk) begin
        t_alu_out e;
        if (i_rst_n && i_valid && !i_in_stall)
            alu_expected_q.push_back(alu_predict(i_op, i_wide, i_operand_a, i_operand_b));
        if (i_rst_n && i_out_valid && !i_stall) begin
            if (alu_expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, i_result);
                o_errors <= o_errors + 1;
            end else begin
                e = alu_expected_q.pop_front();
                if (e.result !== i_result || e.dz !== i_div_by_zero
                        || e.bad !== i_bad_op) begin
                    $display("%0t: mismatch expected %h dz %b bad %b actual %h dz %b bad %b",
                             $time, e.result, e.dz, e.bad,
                             i_result, i_div_by_zero, i_bad_op);
                    o_errors <= o_errors + 1;
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_integer_alu_32_64.sv =====
`timescale 1ns / 100ps
// Testbench top for the 32/64-bit integer ALU: clock, reset, directed and
// random items, random output stalls and the verdict. Uses ia_pkg and the checker.
module tb_integer_alu_32_64;
    import ia_pkg::*;

    localparam int LATENCY = 69;
    localparam int LIMIT   = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  op = '0;
    logic        wide = 1'b0;
    logic [63:0] opa = '0;
    logic [63:0] opb = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result;
    logic        dz;
    logic        bad;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          calm = 1'b0;

    always #2 clk = ~clk;

    integer_alu_32_64 u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_op(op), .i_wide(wide), .i_operand_a(opa), .i_operand_b(opb),
        .o_valid(out_valid), .i_stall(out_stall), .o_result(result),
        .o_div_by_zero(dz), .o_bad_op(bad)
    );

    tb_integer_alu_32_64_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_wide(wide), .i_operand_a(opa), .i_operand_b(opb),
        .i_out_valid(out_valid), .i_stall(out_stall), .i_result(result),
        .i_div_by_zero(dz), .i_bad_op(bad), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 12);
        if (cycles > LIMIT) begin
            $display("** integer_alu_32_64: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return '0;
            3: return {{32{$urandom_range(1) == 1}}, 32'h8000_0000};
            4: return 64'($urandom_range(70));
            5: return {32'($urandom), 32'($urandom)} >> $urandom_range(63);
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic send_item(logic [3:0] o, logic w, logic [63:0] a, logic [63:0] b);
        while (!calm && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        wide <= w;
        opa <= a;
        opb <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        logic [63:0] mn;
        logic [63:0] m1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        mn = 64'h8000_0000_0000_0000;
        m1 = '1;
        for (int k = 0; k < 16; k++) begin
            send_item(4'(k), 1'b0, 64'h1234_5678_8000_0007, 64'hFFFF_0000_0000_0025);
            send_item(4'(k), 1'b1, mn, m1);
        end
        send_item(OP_SDIVN, 1'b0, 64'h0000_0000_8000_0000, m1);
        send_item(OP_SREMN, 1'b0, 64'h0000_0000_8000_0000, m1);
        send_item(OP_SDIVN, 1'b0, 64'd5, 64'hABCD_0000_0000_0000);
        send_item(OP_UDIV, 1'b1, m1, '0);
        send_item(OP_SREMW, 1'b1, m1, '0);
        send_item(OP_SHL, 1'b1, m1, 64'd127);
        for (int n = 0; n < 1050; n++) begin
            calm = (n >= 400 && n < 550);
            send_item(4'($urandom_range(15)), 1'($urandom_range(1)),
                      rand_operand(), rand_operand());
        end
        in_valid <= 1'b0;
        calm = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("** integer_alu_32_64: PASSED **");
        else
            $display("** integer_alu_32_64: FAILED **");
        $finish;
    end

endmodule
